@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge.
`define PPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true at a clock edge.
`define PPS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ hw/rtl/pps_pkg.sv @@
`default_nettype none

package pps_pkg;

  // Field widths
  localparam int PIXEL_W       = 8;
  localparam int COUNT_W       = 18;
  localparam int ROW_BANDS_W   = 9;
  localparam int COL_BANDS_W   = 8;
  localparam int PANEL_W       = 4;
  localparam int FRAME_WIDTH_W  = 9;
  localparam int FRAME_HEIGHT_W = 10;
  localparam int CFG_DATA_W    = 10;
  localparam int CFG_IDX_W     = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 9'd220;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 10'd320;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 512;

  // Pixel classes
  localparam logic [PIXEL_W-1:0] INK_LIMIT    = 8'd245;
  localparam logic [PIXEL_W-1:0] DARK_LIMIT   = 8'd80;
  localparam logic [PIXEL_W-1:0] WHITE_LIMIT  = 8'd245;
  localparam logic [PIXEL_W-1:0] GUTTER_LEVEL = 8'd248;
  localparam int EDGE_LIMIT   = 90;

  // Near-white test: FRAC_DEN * white >= FRAC_NUM * length
  localparam int FRAC_NUM     = 985;
  localparam int FRAC_DEN     = 1000;
  localparam int BAND_MIN_RUN = 4;
  localparam int PANEL_MAX    = 12;

  typedef struct packed {
    logic accept;      // pixel transaction this cycle
    logic scan_issue;  // read next column count
    logic scan_eval;   // column count read last cycle is valid
    logic load;        // load result register, restart frame
  } pps_cmd_t;

  typedef struct packed {
    logic last_pixel;  // current position is last pixel of frame
    logic scan_last;   // scan pointer on last column
    logic out_full;    // result register occupied and not drained
  } pps_stat_t;

  typedef struct packed {
    logic [COUNT_W-1:0]     ink_count;
    logic [COUNT_W-1:0]     dark_count;
    logic [COUNT_W-1:0]     white_count;
    logic [COUNT_W-1:0]     edge_count;
    logic [ROW_BANDS_W-1:0] row_bands;
    logic [COL_BANDS_W-1:0] column_bands;
    logic [PANEL_W-1:0]     panel_estimate;
  } pps_result_t;

endpackage

`default_nettype wire

@@ hw/rtl/pps_if.sv @@
`default_nettype none

interface pps_in_if import pps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface pps_out_if import pps_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [COUNT_W-1:0]     ink_count;
  logic [COUNT_W-1:0]     dark_count;
  logic [COUNT_W-1:0]     white_count;
  logic [COUNT_W-1:0]     edge_count;
  logic [ROW_BANDS_W-1:0] row_bands;
  logic [COL_BANDS_W-1:0] column_bands;
  logic [PANEL_W-1:0]     panel_estimate;

  modport source (output valid, output ink_count, output dark_count, output white_count,
                  output edge_count, output row_bands, output column_bands,
                  output panel_estimate, input ready);
  modport sink (input valid, input ink_count, input dark_count, input white_count,
                input edge_count, input row_bands, input column_bands,
                input panel_estimate, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pps_ctrl.sv @@
`default_nettype none

module pps_ctrl import pps_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire pps_stat_t stat_i,
  output pps_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    ST_RUN    = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_FINISH = 4'b0100,
    ST_HOLD   = 4'b1000
  } pps_state_e;

  pps_state_e state_q, state_d;
  logic       eval_q, eval_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == ST_RUN);
    cmd_o.scan_eval = eval_q;
    case (state_q)
      ST_RUN: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && stat_i.last_pixel) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // last column evaluated this cycle
        state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (!stat_i.out_full) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
    // config write restarts the frame
    if (cfg_we_i) begin
      state_d = ST_RUN;
    end
    eval_d = (state_q == ST_SCAN) && !cfg_we_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      eval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      eval_q  <= eval_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pps_datapath.sv @@
`default_nettype none

module pps_datapath import pps_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [PIXEL_W-1:0]    pixel_i,
  input  wire pps_cmd_t              cmd_i,
  output pps_stat_t                  stat_o,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output pps_result_t                result_o
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RPW = WW + 10;
  localparam int CPW = HW + 10;

  // Config registers
  logic [FRAME_WIDTH_W-1:0]  fw_q;
  logic [FRAME_HEIGHT_W-1:0] fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FRAME_WIDTH_RST;
      fh_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  fw_q <= cfg_data_i[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: fh_q <= cfg_data_i[FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective size: zero reads as one, saturate at the maximum
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [XW-1:0] wm1;
  logic [YW-1:0] hm1;

  always_comb begin
    if (fw_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_q);
    end
    if (fh_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(fh_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(fh_q);
    end
  end

  assign wm1 = XW'(w_eff - WW'(1));
  assign hm1 = YW'(h_eff - HW'(1));

  logic restart;
  logic accept;
  assign restart = cfg_we_i | cmd_i.load;
  assign accept  = cmd_i.accept;

  // Raster position
  logic [XW-1:0] col_q, col_d;
  logic [YW-1:0] row_q, row_d;
  logic          last_col, last_row;

  assign last_col = (col_q == wm1);
  assign last_row = (row_q == hm1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + YW'(1);
      end else begin
        col_d = col_q + XW'(1);
      end
    end
  end

  // Pixel classification
  logic [PIXEL_W-1:0] left_q;
  logic [PIXEL_W-1:0] up_q;
  logic [PIXEL_W-1:0] d_left, d_up;
  logic [PIXEL_W:0]   edge_sum;
  logic               is_ink, is_dark, is_white, is_gutter, is_edge;

  assign d_left   = (pixel_i > left_q) ? pixel_i - left_q : left_q - pixel_i;
  assign d_up     = (pixel_i > up_q) ? pixel_i - up_q : up_q - pixel_i;
  assign edge_sum = {1'b0, d_left} + {1'b0, d_up};
  assign is_ink    = pixel_i < INK_LIMIT;
  assign is_dark   = pixel_i < DARK_LIMIT;
  assign is_white  = pixel_i > WHITE_LIMIT;
  assign is_gutter = pixel_i > GUTTER_LEVEL;
  assign is_edge   = (col_q != '0) && (row_q != '0) && (edge_sum > (PIXEL_W + 1)'(EDGE_LIMIT));

  // Line store: read next column ahead, bypass same-address write
  logic [PIXEL_W-1:0] line_mem [MAX_WIDTH];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_mem[col_q] <= pixel_i;
    end
    if (accept && (col_d == col_q)) begin
      up_q <= pixel_i;
    end else begin
      up_q <= line_mem[col_d];
    end
  end

  // Column white counts; row zero starts each column from zero
  logic [HW-1:0] cw_mem [MAX_WIDTH];
  logic [HW-1:0] cw_rd_q;
  logic [HW-1:0] cw_new;
  logic [XW-1:0] sc_q;
  logic [XW-1:0] rd_addr;

  assign cw_new  = ((row_q == '0) ? '0 : cw_rd_q) + HW'(is_gutter);
  assign rd_addr = cmd_i.scan_issue ? sc_q : col_d;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cw_mem[col_q] <= cw_new;
    end
    if (accept && (rd_addr == col_q)) begin
      cw_rd_q <= cw_new;
    end else begin
      cw_rd_q <= cw_mem[rd_addr];
    end
  end

  // Row gutter test
  logic [WW-1:0]  row_white_q;
  logic [WW-1:0]  row_white_sum;
  logic           row_nw;
  logic [HW-1:0]  row_run_q;
  logic [HW-1:0]  row_band_q;

  assign row_white_sum = row_white_q + WW'(is_gutter);
  assign row_nw = (RPW'(row_white_sum) * RPW'(FRAC_DEN)) >= (RPW'(w_eff) * RPW'(FRAC_NUM));

  // Column gutter test during the scan
  logic           col_nw;
  logic [WW-1:0]  col_run_q;
  logic [WW-1:0]  col_band_q;

  assign col_nw = (CPW'(cw_rd_q) * CPW'(FRAC_DEN)) >= (CPW'(h_eff) * CPW'(FRAC_NUM));

  // Class counters
  logic [COUNT_W-1:0] ink_q, dark_q, white_q, edge_q;

  // Final figures
  logic [HW-1:0] rows_full;
  logic [WW-1:0] cols_full;
  logic [7:0]    panel_prod;
  logic [PANEL_W-1:0] panel;

  assign rows_full  = row_band_q + HW'(row_run_q >= HW'(BAND_MIN_RUN));
  assign cols_full  = col_band_q + WW'(col_run_q >= WW'(BAND_MIN_RUN));
  assign panel_prod = ({4'b0, 4'(rows_full)} + 8'd1) * ({4'b0, 4'(cols_full)} + 8'd1);

  always_comb begin
    if ((rows_full >= HW'(PANEL_MAX)) || (cols_full >= WW'(PANEL_MAX))) begin
      panel = PANEL_W'(PANEL_MAX);
    end else if (panel_prod > 8'(PANEL_MAX)) begin
      panel = PANEL_W'(PANEL_MAX);
    end else begin
      panel = panel_prod[PANEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
      row_white_q <= '0;
      row_run_q   <= '0;
      row_band_q  <= '0;
      col_run_q   <= '0;
      col_band_q  <= '0;
      sc_q        <= '0;
      ink_q       <= '0;
      dark_q      <= '0;
      white_q     <= '0;
      edge_q      <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (restart) begin
        left_q      <= '0;
        row_white_q <= '0;
        row_run_q   <= '0;
        row_band_q  <= '0;
        col_run_q   <= '0;
        col_band_q  <= '0;
        ink_q       <= '0;
        dark_q      <= '0;
        white_q     <= '0;
        edge_q      <= '0;
      end else begin
        if (accept) begin
          left_q  <= pixel_i;
          ink_q   <= ink_q + COUNT_W'(is_ink);
          dark_q  <= dark_q + COUNT_W'(is_dark);
          white_q <= white_q + COUNT_W'(is_white);
          edge_q  <= edge_q + COUNT_W'(is_edge);
          if (last_col) begin
            row_white_q <= '0;
            if (row_nw) begin
              row_run_q <= row_run_q + HW'(1);
            end else begin
              if (row_run_q >= HW'(BAND_MIN_RUN)) begin
                row_band_q <= row_band_q + HW'(1);
              end
              row_run_q <= '0;
            end
          end else begin
            row_white_q <= row_white_sum;
          end
        end
        if (cmd_i.scan_eval) begin
          if (col_nw) begin
            col_run_q <= col_run_q + WW'(1);
          end else begin
            if (col_run_q >= WW'(BAND_MIN_RUN)) begin
              col_band_q <= col_band_q + WW'(1);
            end
            col_run_q <= '0;
          end
        end
      end
      if (accept) begin
        sc_q <= '0;
      end else if (cmd_i.scan_issue) begin
        sc_q <= sc_q + XW'(1);
      end
    end
  end

  // Result register
  logic        out_valid_q;
  pps_result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q.ink_count      <= ink_q;
      res_q.dark_count     <= dark_q;
      res_q.white_count    <= white_q;
      res_q.edge_count     <= edge_q;
      res_q.row_bands      <= ROW_BANDS_W'(rows_full);
      res_q.column_bands   <= COL_BANDS_W'(cols_full);
      res_q.panel_estimate <= panel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  assign stat_o.last_pixel = last_col && last_row;
  assign stat_o.scan_last  = (sc_q == wm1);
  assign stat_o.out_full   = out_valid_q && !out_ready_i;

endmodule

`default_nettype wire

@@ hw/rtl/page_pixel_statistics_unit.sv @@
// Channel   Dir  Type         Payload
// pix_i     in   pps_in_if    pixel, 8 bit, raster order
// res_o     out  pps_out_if   four class counts, row/column bands, panel estimate
// cfg_*     in   write port   frame_width (index 0), frame_height (index 1)
//
// One pixel per cycle while a frame streams in.
// After the last pixel, the column counts are scanned out of the column memory, one
// column a cycle; the result then loads once the result register has drained.
// Reset is asynchronous and active low; no memory clearing pass is needed.
// A stall on res_o only holds the block once a second result is ready to load.
`default_nettype none
`include "assert_macros.svh"

module page_pixel_statistics_unit import pps_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  pps_in_if.sink                     pix_i,
  pps_out_if.source                  res_o
);

  pps_cmd_t    cmd;
  pps_stat_t   st;
  logic        in_ready;
  logic        out_valid;
  pps_result_t result;

  // Controller: frame streaming, column scan, result hand-off
  pps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (pix_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (st),
    .cmd_o      (cmd)
  );

  // Datapath: counters, line store, column memory, band logic, result register
  pps_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pixel_i     (pix_i.pixel),
    .cmd_i       (cmd),
    .stat_o      (st),
    .out_ready_i (res_o.ready),
    .out_valid_o (out_valid),
    .result_o    (result)
  );

  assign pix_i.ready          = in_ready;
  assign res_o.valid          = out_valid;
  assign res_o.ink_count      = result.ink_count;
  assign res_o.dark_count     = result.dark_count;
  assign res_o.white_count    = result.white_count;
  assign res_o.edge_count     = result.edge_count;
  assign res_o.row_bands      = result.row_bands;
  assign res_o.column_bands   = result.column_bands;
  assign res_o.panel_estimate = result.panel_estimate;

  // No pixel transaction while the column memory is scanned or a result loads
  `PPS_ASSERT_NEVER(a_no_pixel_in_scan, pix_i.ready && (cmd.scan_issue || cmd.load), "pixel taken during scan")
  // Last pixel of a frame starts the column scan
  `PPS_ASSERT(a_scan_follows_frame, (pix_i.valid && pix_i.ready && st.last_pixel && !cfg_we_i) |=> cmd.scan_issue, "scan did not start")
  // A loaded result is offered on the next cycle
  `PPS_ASSERT(a_load_shows_result, cmd.load |=> res_o.valid, "result lost")
  // Panel estimate stays within its clamp
  `PPS_ASSERT(a_panel_range, res_o.valid |-> ((res_o.panel_estimate != 4'd0) && (res_o.panel_estimate <= 4'd12)), "panel out of range")

endmodule

`default_nettype wire

@@ tb/tb_page_pixel_statistics_unit.sv @@
module tb_page_pixel_statistics_unit;
  import pps_pkg::*;

  // After the last pixel the block scans every column before the result shows;
  // this margin covers the widest frame before a register write or the end of the run.
  localparam int SETTLE_CYCLES = DEF_MAX_WIDTH + 44;
  localparam int LONG_HOLD     = 2000;       // receiver blackout, in cycles
  localparam int CYCLE_LIMIT   = 6_000_000;  // hang guard
  localparam int ITEM_TARGET   = 850;        // at least this many pixel transactions in the run

  // What the sender does with each queued entry
  typedef enum logic [1:0] {
    STIM_PIXEL,   // offer one pixel transaction
    STIM_SETTLE,  // wait for every frame result, then let the scan finish
    STIM_WRITE    // one register write
  } stim_kind_e;

  typedef struct {
    stim_kind_e             kind;
    logic [PIXEL_W-1:0]     pixel;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
  } stim_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pps_in_if  pix_if ();
  pps_out_if res_if ();

  page_pixel_statistics_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_if),
    .res_o      (res_if)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Frame statistics predictor: own copy of registers and frame state
  // ---------------------------------------------------------------------------
  logic [FRAME_WIDTH_W-1:0]  cur_width;
  logic [FRAME_HEIGHT_W-1:0] cur_height;
  logic [7:0]                col_at;
  logic [8:0]                row_at;
  logic [PIXEL_W-1:0]        line_mem [DEF_MAX_WIDTH];
  logic [PIXEL_W-1:0]        left_px;
  logic [9:0]                col_white [DEF_MAX_WIDTH];
  logic [8:0]                row_white;
  logic [9:0]                white_run;
  logic [8:0]                band_rows;
  logic [COUNT_W-1:0]        ink_n, dark_n, white_n, edge_n;

  pps_result_t frame_results_q[$];  // expected results, oldest first
  stim_t       stim_q[$];           // pending sender entries

  int error_count    = 0;
  int pixels_taken   = 0;
  int planned_pixels = 0;
  int hold_trigger   = 0;
  int cycle_count    = 0;

  function automatic int unsigned eff_dim(int unsigned v, int unsigned cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  function automatic int unsigned abs_diff(int unsigned a, int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Near-white line: at least 98.5% of pixels above the gutter level
  function automatic bit gutter_line(int unsigned white, int unsigned len);
    return FRAC_DEN * white >= FRAC_NUM * len;
  endfunction

  function automatic void restart_stats();
    col_at    = '0;
    row_at    = '0;
    left_px   = '0;
    row_white = '0;
    white_run = '0;
    band_rows = '0;
    ink_n     = '0;
    dark_n    = '0;
    white_n   = '0;
    edge_n    = '0;
    foreach (col_white[i]) col_white[i] = '0;
  endfunction

  function automatic void stats_reset();
    cur_width  = FRAME_WIDTH_RST;
    cur_height = FRAME_HEIGHT_RST;
    foreach (line_mem[i]) line_mem[i] = '0;
    restart_stats();
  endfunction

  // A register write abandons whatever frame is in flight
  function automatic void stats_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_FRAME_WIDTH: begin
        cur_width = data[FRAME_WIDTH_W-1:0];
        restart_stats();
      end
      REG_FRAME_HEIGHT: begin
        cur_height = data[FRAME_HEIGHT_W-1:0];
        restart_stats();
      end
      default: ;
    endcase
  endfunction

  // One pixel in; returns 1 with the frame result on the last pixel of a frame
  function automatic bit stats_pixel(input logic [PIXEL_W-1:0] px, output pps_result_t res);
    int unsigned w, h, x, y, rows, cols, run, panels;
    w   = eff_dim(cur_width, DEF_MAX_WIDTH);
    h   = eff_dim(cur_height, DEF_MAX_HEIGHT);
    x   = col_at;
    y   = row_at;
    res = '0;
    if (x >= w) x = w - 1;
    if (y >= h) y = h - 1;

    if (px < INK_LIMIT) ink_n++;
    if (px < DARK_LIMIT) dark_n++;
    if (px > WHITE_LIMIT) white_n++;
    // edges only where both a left and an upper neighbour exist
    if (x > 0 && y > 0) begin
      if (abs_diff(px, left_px) + abs_diff(px, line_mem[x]) > EDGE_LIMIT) edge_n++;
    end
    line_mem[x] = px;
    left_px     = px;
    if (px > GUTTER_LEVEL) begin
      row_white++;
      col_white[x]++;
    end

    if (x + 1 < w) begin
      col_at = 8'(x + 1);
      row_at = 9'(y);
      return 1'b0;
    end

    // row complete
    if (gutter_line(row_white, w)) begin
      white_run++;
    end else begin
      if (white_run >= BAND_MIN_RUN) band_rows++;
      white_run = '0;
    end
    row_white = '0;
    col_at    = '0;
    if (y + 1 < h) begin
      row_at = 9'(y + 1);
      return 1'b0;
    end

    // frame complete: column scan
    rows = band_rows + ((white_run >= BAND_MIN_RUN) ? 1 : 0);
    cols = 0;
    run  = 0;
    for (int unsigned i = 0; i < w; i++) begin
      if (gutter_line(col_white[i], h)) begin
        run++;
      end else begin
        if (run >= BAND_MIN_RUN) cols++;
        run = 0;
      end
    end
    if (run >= BAND_MIN_RUN) cols++;
    panels = (rows + 1) * (cols + 1);
    if (panels > PANEL_MAX) panels = PANEL_MAX;
    if (panels < 1) panels = 1;

    res.ink_count      = ink_n;
    res.dark_count     = dark_n;
    res.white_count    = white_n;
    res.edge_count     = edge_n;
    res.row_bands      = 9'(rows);
    res.column_bands   = 8'(cols);
    res.panel_estimate = 4'(panels);
    restart_stats();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Error reporting
  // ---------------------------------------------------------------------------
  task automatic report_error(string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_error($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  bit gut_mask [2][DEF_MAX_HEIGHT];  // [0] gutter rows, [1] gutter columns
  logic [FRAME_WIDTH_W-1:0]  plan_width  = FRAME_WIDTH_RST;
  logic [FRAME_HEIGHT_W-1:0] plan_height = FRAME_HEIGHT_RST;

  function automatic void push_pixel(logic [PIXEL_W-1:0] p);
    stim_t s;
    s.kind  = STIM_PIXEL;
    s.pixel = p;
    s.idx   = REG_FRAME_WIDTH;
    s.data  = '0;
    stim_q  = {stim_q, s};
    planned_pixels++;
  endfunction

  function automatic void push_settle();
    stim_t s;
    s.kind  = STIM_SETTLE;
    s.pixel = '0;
    s.idx   = REG_FRAME_WIDTH;
    s.data  = '0;
    stim_q  = {stim_q, s};
  endfunction

  function automatic void push_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_t s;
    s.kind  = STIM_WRITE;
    s.pixel = '0;
    s.idx   = idx;
    s.data  = data;
    stim_q  = {stim_q, s};
    if (idx == REG_FRAME_WIDTH) plan_width = data[FRAME_WIDTH_W-1:0];
    else plan_height = data[FRAME_HEIGHT_W-1:0];
  endfunction

  // Alternating runs of gutter and content lines, short enough to form several bands
  function automatic void mark_runs(int sel, int unsigned n);
    int unsigned i, len;
    bit          white;
    i     = 0;
    white = bit'($urandom_range(0, 1));
    while (i < n) begin
      len = white ? $urandom_range(1, 7) : $urandom_range(1, 6);
      for (int unsigned k = 0; k < len && i < n; k++) begin
        gut_mask[sel][i] = white;
        i++;
      end
      white = !white;
    end
  endfunction

  // Gutter pixels are almost always above the gutter level; the rare content-valued one
  // sits right at the 98.5% boundary for tall columns
  function automatic logic [PIXEL_W-1:0] pick_pixel(bit gutter);
    if (gutter && $urandom_range(0, 63) != 0) return 8'($urandom_range(249, 255));
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return DARK_LIMIT - 8'd1;
      3:       return DARK_LIMIT;
      4:       return INK_LIMIT - 8'd1;
      5:       return WHITE_LIMIT;
      6:       return WHITE_LIMIT + 8'd1;
      7:       return GUTTER_LEVEL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Whole frame; fill < 0 gives gutter structure, otherwise a flat frame
  function automatic int add_frame(int unsigned w, int unsigned h, int fill);
    if (fill < 0) begin
      mark_runs(0, h);
      mark_runs(1, w);
    end
    for (int unsigned y = 0; y < h; y++) begin
      for (int unsigned x = 0; x < w; x++) begin
        if (fill < 0) push_pixel(pick_pixel(gut_mask[0][y] || gut_mask[1][x]));
        else push_pixel(8'(fill));
      end
    end
    return w * h;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of pixel transactions, random gaps, settles and register writes
  // ---------------------------------------------------------------------------
  int hold_left, gap_left, burst_left;

  always @(posedge clk_i or negedge rst_ni) begin : pixel_driver
    stim_t       head;
    pps_result_t res;
    logic        nxt_valid;
    logic        nxt_we;
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
      pix_if.pixel <= '0;
      cfg_we_i     <= 1'b0;
      cfg_idx_i    <= REG_FRAME_WIDTH;
      cfg_data_i   <= '0;
      hold_left    = 0;
      gap_left     = 0;
      burst_left   = 0;
    end else begin
      nxt_valid = pix_if.valid;
      nxt_we    = 1'b0;
      // accepted transaction: predict here so the expectation exists before any settle
      if (pix_if.valid && pix_if.ready) begin
        nxt_valid = 1'b0;
        pixels_taken++;
        if (stats_pixel(pix_if.pixel, res)) frame_results_q = {frame_results_q, res};
      end
      if (!nxt_valid) begin
        if (hold_left != 0) begin
          hold_left--;
        end else if (gap_left != 0) begin
          gap_left--;
        end else if (stim_q.size() != 0) begin
          head = stim_q[0];
          case (head.kind)
            STIM_PIXEL: begin
              nxt_valid = 1'b1;
              pix_if.pixel <= head.pixel;
              void'(stim_q.pop_front());
              if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(150, 400)
                                                         : $urandom_range(1, 30);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
              end else begin
                burst_left--;
              end
            end
            STIM_SETTLE: begin
              if (frame_results_q.size() == 0) begin
                hold_left = SETTLE_CYCLES;
                void'(stim_q.pop_front());
              end
            end
            STIM_WRITE: begin
              // lands at the next edge; no pixel can be accepted before it
              nxt_we = 1'b1;
              cfg_idx_i  <= head.idx;
              cfg_data_i <= head.data;
              stats_write(head.idx, head.data);
              void'(stim_q.pop_front());
            end
            default: ;
          endcase
        end
      end
      pix_if.valid <= nxt_valid;
      cfg_we_i     <= nxt_we;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern of its own plus one long blackout
  // ---------------------------------------------------------------------------
  rx_mode_e rx_mode;
  int       rx_left;
  int       blackout_left;
  bit       blackout_done;

  always @(posedge clk_i or negedge rst_ni) begin : result_sink
    if (!rst_ni) begin
      res_if.ready  <= 1'b0;
      rx_mode       = RX_OPEN;
      rx_left       = 0;
      blackout_left = 0;
      blackout_done = 1'b0;
    end else begin
      // one long hold-off: frames pile up until the block stalls its input
      if (!blackout_done && hold_trigger != 0 && pixels_taken >= hold_trigger) begin
        blackout_left = LONG_HOLD;
        blackout_done = 1'b1;
      end
      if (blackout_left != 0) begin
        blackout_left--;
        res_if.ready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 3));
          rx_left = $urandom_range(8, 60);
        end else begin
          rx_left--;
        end
        case (rx_mode)
          RX_OPEN:   res_if.ready <= 1'b1;
          RX_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: res_if.ready <= ($urandom_range(0, 7) == 0);
          default:   res_if.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: each result transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    pps_result_t seen, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen = {res_if.ink_count, res_if.dark_count, res_if.white_count, res_if.edge_count,
              res_if.row_bands, res_if.column_bands, res_if.panel_estimate};
      if (frame_results_q.size() == 0) begin
        report_error("result transaction with no frame pending");
      end else begin
        want = frame_results_q.pop_front();
        check_field("ink_count", seen.ink_count, want.ink_count);
        check_field("dark_count", seen.dark_count, want.dark_count);
        check_field("white_count", seen.white_count, want.white_count);
        check_field("edge_count", seen.edge_count, want.edge_count);
        check_field("row_bands", seen.row_bands, want.row_bands);
        check_field("column_bands", seen.column_bands, want.column_bands);
        check_field("panel_estimate", seen.panel_estimate, want.panel_estimate);
      end
    end
  end

  // Hang guard
  always @(posedge clk_i) begin : cycle_guard
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin : run_ctrl
    int          nfr, pick, part;
    int unsigned w, h;
    logic [CFG_DATA_W-1:0] wdata, hdata;
    logic [PIXEL_W-1:0]    singles [9];

    stats_reset();
    rst_ni <= 1'b0;

    // Reset width kept: only the height is written, one full row at the default width
    push_write(REG_FRAME_HEIGHT, 10'd1);
    void'(add_frame(FRAME_WIDTH_RST, 1, -1));

    // 1x1 frames across the class thresholds
    push_settle();
    push_write(REG_FRAME_WIDTH, 10'd1);
    push_write(REG_FRAME_HEIGHT, 10'd1);
    singles = '{8'd0, 8'd255, DARK_LIMIT - 8'd1, DARK_LIMIT, INK_LIMIT - 8'd1,
                WHITE_LIMIT, WHITE_LIMIT + 8'd1, GUTTER_LEVEL, GUTTER_LEVEL + 8'd1};
    foreach (singles[i]) push_pixel(singles[i]);

    // zero width and height act as one
    push_settle();
    push_write(REG_FRAME_WIDTH, 10'd0);
    push_write(REG_FRAME_HEIGHT, 10'd0);
    push_pixel(8'd128);

    // 2x2: edge threshold exactly at the limit, one above, and a strong diagonal;
    // first-row and first-column neighbours never count
    push_settle();
    push_write(REG_FRAME_WIDTH, 10'd2);
    push_write(REG_FRAME_HEIGHT, 10'd2);
    push_pixel(8'd255); push_pixel(8'd1); push_pixel(8'd91); push_pixel(8'd91);
    push_pixel(8'd255); push_pixel(8'd0); push_pixel(8'd91); push_pixel(8'd91);
    push_pixel(8'd0);   push_pixel(8'd255); push_pixel(8'd255); push_pixel(8'd0);

    // width data with the unused top bit set
    push_settle();
    push_write(REG_FRAME_WIDTH, 10'h205);
    push_write(REG_FRAME_HEIGHT, 10'd2);
    void'(add_frame(5, 2, -1));

    // width saturating, one row across the whole line store
    push_settle();
    push_write(REG_FRAME_WIDTH, 10'd511);
    push_write(REG_FRAME_HEIGHT, 10'd1);
    void'(add_frame(DEF_MAX_WIDTH, 1, -1));

    // register write in the middle of a frame abandons it
    push_settle();
    push_write(REG_FRAME_WIDTH, 10'd3);
    push_write(REG_FRAME_HEIGHT, 10'd3);
    for (int i = 0; i < 5; i++) push_pixel(8'($urandom_range(0, 255)));
    push_settle();
    push_write(REG_FRAME_HEIGHT, 10'd2);
    void'(add_frame(3, 2, -1));

    // small frames with no settle between them; the receiver blackout starts on
    // the first pixel, so finished frames back up and stall the input
    push_settle();
    push_write(REG_FRAME_WIDTH, 10'd2);
    push_write(REG_FRAME_HEIGHT, 10'd2);
    hold_trigger = planned_pixels + 1;
    for (int f = 0; f < 6; f++) void'(add_frame(2, 2, -1));

    // Random phases: settle, new size, a few structured frames, sometimes cut short
    while (planned_pixels < ITEM_TARGET) begin
      push_settle();
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        wdata = 10'($urandom_range(0, 1));
        hdata = 10'($urandom_range(0, 3));
      end else if (pick <= 3) begin
        wdata = 10'($urandom_range(17, 32));
        hdata = 10'($urandom_range(2, 4));
      end else begin
        wdata = 10'($urandom_range(1, 12));
        hdata = 10'($urandom_range(1, 10));
      end
      wdata[9] = 1'($urandom_range(0, 1));  // ignored by the width register
      case ($urandom_range(0, 3))
        0: push_write(REG_FRAME_WIDTH, wdata);
        1: push_write(REG_FRAME_HEIGHT, hdata);
        2: begin
          push_write(REG_FRAME_WIDTH, wdata);
          push_write(REG_FRAME_HEIGHT, hdata);
        end
        default: begin
          push_write(REG_FRAME_HEIGHT, hdata);
          push_write(REG_FRAME_WIDTH, wdata);
        end
      endcase
      w   = eff_dim(plan_width, DEF_MAX_WIDTH);
      h   = eff_dim(plan_height, DEF_MAX_HEIGHT);
      nfr = (w * h > 64) ? 1 : $urandom_range(1, 3);
      for (int f = 0; f < nfr; f++) void'(add_frame(w, h, -1));
      // partial frame, dropped by the next phase's write
      if (w * h > 1 && $urandom_range(0, 5) == 0) begin
        part = $urandom_range(1, w * h - 1);
        for (int i = 0; i < part; i++) push_pixel(pick_pixel(1'b0));
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || pix_if.valid || frame_results_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (frame_results_q.size() != 0)
      report_error($sformatf("%0d frame results never arrived", frame_results_q.size()));

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
